// ===== hw/rtl/kcc_pkg.sv =====
`default_nettype none

package kcc_pkg;

    localparam int KEY_IDX_W = 3;
    localparam int TICK_W    = 8;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_PRESSED  = 3'd2,
        PH_LONG     = 3'd3,
        PH_WAIT     = 3'd4,
        PH_SECOND   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } click_kind_t;

    localparam logic [1:0] REG_LONG_PRESS  = 2'd0;
    localparam logic [1:0] REG_DOUBLE_WAIT = 2'd1;
    localparam logic [1:0] REG_PRESS_LEVEL = 2'd2;

    localparam logic [TICK_W-1:0] LONG_PRESS_RST  = 8'd50;
    localparam logic [TICK_W-1:0] DOUBLE_WAIT_RST = 8'd25;

    typedef struct packed {
        logic [TICK_W-1:0] long_press_ticks;
        logic [TICK_W-1:0] double_wait_ticks;
        logic              pressed_level;
    } cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic [TICK_W-1:0] count;
        click_kind_t       click_kind;
    } step_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kcc_cfg_regs.sv =====
`default_nettype none

module kcc_cfg_regs
    import kcc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks  <= LONG_PRESS_RST;
            cfg_reg.double_wait_ticks <= DOUBLE_WAIT_RST;
            cfg_reg.pressed_level     <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_LONG_PRESS:  cfg_reg.long_press_ticks  <= pwdata[TICK_W-1:0];
                REG_DOUBLE_WAIT: cfg_reg.double_wait_ticks <= pwdata[TICK_W-1:0];
                REG_PRESS_LEVEL: cfg_reg.pressed_level     <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_LONG_PRESS:  prdata[TICK_W-1:0] = cfg_reg.long_press_ticks;
            REG_DOUBLE_WAIT: prdata[TICK_W-1:0] = cfg_reg.double_wait_ticks;
            REG_PRESS_LEVEL: prdata[0]          = cfg_reg.pressed_level;
            default:         prdata             = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/kcc_step.sv =====
`default_nettype none

module kcc_step
    import kcc_pkg::*;
(
    input  wire phase_t            phase,
    input  wire logic [TICK_W-1:0] count,
    input  wire logic              pressed,
    input  wire cfg_t              cfg,
    output step_t                  result
);

    logic              long_hit;
    logic              wait_hit;
    logic [TICK_W-1:0] count_inc;

    assign long_hit  = count >= cfg.long_press_ticks;
    assign wait_hit  = count >= cfg.double_wait_ticks;
    assign count_inc = count + TICK_W'(1);

    always_comb
    begin
        result.phase      = phase;
        result.count      = count;
        result.click_kind = EV_NONE;
        unique case (phase)
            PH_DEBOUNCE:
            begin
                result.phase = pressed ? PH_PRESSED : PH_IDLE;
            end
            PH_PRESSED:
            begin
                if (pressed && long_hit)
                begin
                    result.phase = PH_LONG;
                    result.count = '0;
                end
                else if (pressed)
                begin
                    result.count = count_inc;
                end
                else
                begin
                    result.phase = PH_WAIT;
                    result.count = '0;
                end
            end
            PH_LONG:
            begin
                result.count = '0;
                if (!pressed)
                begin
                    result.phase      = PH_IDLE;
                    result.click_kind = EV_LONG;
                end
            end
            PH_WAIT:
            begin
                if (!pressed && wait_hit)
                begin
                    result.phase      = PH_IDLE;
                    result.count      = '0;
                    result.click_kind = EV_SINGLE;
                end
                else if (!pressed)
                begin
                    result.count = count_inc;
                end
                else
                begin
                    result.phase = PH_SECOND;
                    result.count = '0;
                end
            end
            PH_SECOND:
            begin
                if (pressed && long_hit)
                begin
                    result.phase      = PH_LONG;
                    result.count      = '0;
                    result.click_kind = EV_SINGLE;
                end
                else if (pressed)
                begin
                    result.count = count_inc;
                end
                else
                begin
                    result.phase      = PH_IDLE;
                    result.count      = '0;
                    result.click_kind = EV_DOUBLE;
                end
            end
            default:
            begin
                result.phase = pressed ? PH_DEBOUNCE : PH_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/key_click_classifier_core.sv =====
`default_nettype none

// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tick sample: key index, pin level
// m_*       out  m_tvalid/m_tready  classified event with its key index
// apb       in   psel/penable       thresholds and pressed level
//
// one tick sample per cycle sustained while the output is not stalled
// path: input register, per-key state read and update, result register
// per-key state lives in flip-flops, one entry per key, updated in beat order
// rst_n clears all keys to idle with zero count and loads default thresholds
// a stalled output holds its beat; the input register keeps taking beats while
// the result register is free or drains in the same cycle

module key_click_classifier_core
    import kcc_pkg::*;
#(
    parameter int NUM_KEYS = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // key_index[2:0], pin_level[3], zero pad
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [7:0]        m_tdata,   // click_kind[1:0], event_key[4:2], zero pad
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int EXT_W = KEY_W + KEY_IDX_W;

    cfg_t cfg;

    logic                 s1_valid_reg;
    logic [KEY_IDX_W-1:0] s1_key_reg;
    logic                 s1_pin_reg;
    logic                 s1_adv;

    phase_t               phase_reg [NUM_KEYS];
    logic [TICK_W-1:0]    count_reg [NUM_KEYS];

    logic [EXT_W-1:0]     key_ext;
    logic [KEY_W-1:0]     key_sel;
    logic                 key_ok;
    phase_t               cur_phase;
    logic [TICK_W-1:0]    cur_count;
    logic                 pressed;
    step_t                step;

    logic                 out_valid_reg;
    click_kind_t          event_reg;
    logic [KEY_IDX_W-1:0] event_key_reg;

    kcc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_key_reg <= s_tdata[KEY_IDX_W-1:0];
            s1_pin_reg <= s_tdata[KEY_IDX_W];
        end
    end

    assign key_ext   = {{KEY_W{1'b0}}, s1_key_reg};
    assign key_sel   = key_ext[KEY_W-1:0];
    assign key_ok    = key_ext < EXT_W'(NUM_KEYS);
    assign cur_phase = key_ok ? phase_reg[key_sel] : PH_IDLE;
    assign cur_count = key_ok ? count_reg[key_sel] : '0;
    assign pressed   = s1_pin_reg == cfg.pressed_level;

    kcc_step u_step (
        .phase   (cur_phase),
        .count   (cur_count),
        .pressed (pressed),
        .cfg     (cfg),
        .result  (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                phase_reg[i] <= PH_IDLE;
                count_reg[i] <= '0;
            end
        end
        else if (s1_adv && key_ok)
        begin
            phase_reg[key_sel] <= step.phase;
            count_reg[key_sel] <= step.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            event_reg     <= key_ok ? step.click_kind : EV_NONE;
            event_key_reg <= s1_key_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, event_key_reg, event_reg};

    // idle and debounce keys never carry a count
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && key_ok && (cur_phase == PH_IDLE || cur_phase == PH_DEBOUNCE))
        |-> cur_count == '0)
        else $error("count nonzero in idle or debounce");

    // long-held keeps its count cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && key_ok && cur_phase == PH_LONG) |-> cur_count == '0)
        else $error("count nonzero in long-held");

    // every advanced sample shows up as an output beat
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> m_tvalid)
        else $error("sample advanced without output beat");

    // keys beyond the table never report an event
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !key_ok) |=> event_reg == EV_NONE)
        else $error("event reported for absent key");

    // empty input register always takes a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_tready)
        else $error("input stalled while empty");

endmodule

`default_nettype wire

// ===== sim/key_click_classifier_core_tb.sv =====
`default_nettype none

module key_click_classifier_core_tb
    import kcc_pkg::*;
();

    localparam int KEYS = 8;

    typedef struct {
        click_kind_t      ev;
        logic [2:0]       key;
    } click_beat_t;

    typedef struct {
        logic [2:0]       key;
        logic             pin;
        bit               typed;
        click_kind_t      ev;
    } tick_row_t;

    typedef struct {
        int               long_ticks;
        int               wait_ticks;
        int               level;
        int               num_keys;
        int               ticks;
        bit               no_idle;
    } gesture_plan_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;   // key_index[2:0], pin_level[3], zero pad
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;   // click_kind[1:0], event_key[4:2], zero pad
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    logic [TICK_W-1:0]      cfg_long;
    logic [TICK_W-1:0]      cfg_wait;
    logic                   cfg_level;
    phase_t                 key_phase_q [KEYS];
    logic [TICK_W-1:0]      key_ticks_q [KEYS];

    click_beat_t            pending_clicks[$];
    int                     err_count;
    bit                     no_idle;

    logic                   run_level [KEYS];
    int                     run_left [KEYS];

    // long press thresholds 1, wait 1, pressed level 0
    tick_row_t directed_rows [24] = '{
        '{3'd0, 1'b0, 1'b1, EV_NONE},
        '{3'd0, 1'b0, 1'b0, EV_NONE},
        '{3'd0, 1'b1, 1'b0, EV_NONE},
        '{3'd0, 1'b1, 1'b0, EV_NONE},
        '{3'd0, 1'b1, 1'b1, EV_SINGLE},
        '{3'd1, 1'b0, 1'b0, EV_NONE},
        '{3'd1, 1'b0, 1'b0, EV_NONE},
        '{3'd1, 1'b1, 1'b0, EV_NONE},
        '{3'd1, 1'b0, 1'b0, EV_NONE},
        '{3'd1, 1'b1, 1'b1, EV_DOUBLE},
        '{3'd7, 1'b0, 1'b0, EV_NONE},
        '{3'd7, 1'b0, 1'b0, EV_NONE},
        '{3'd7, 1'b0, 1'b0, EV_NONE},
        '{3'd7, 1'b0, 1'b0, EV_NONE},
        '{3'd7, 1'b1, 1'b1, EV_LONG},
        '{3'd3, 1'b0, 1'b0, EV_NONE},
        '{3'd3, 1'b0, 1'b0, EV_NONE},
        '{3'd3, 1'b1, 1'b0, EV_NONE},
        '{3'd3, 1'b0, 1'b0, EV_NONE},
        '{3'd3, 1'b0, 1'b0, EV_NONE},
        '{3'd3, 1'b0, 1'b1, EV_SINGLE},
        '{3'd3, 1'b1, 1'b1, EV_LONG},
        '{3'd2, 1'b0, 1'b0, EV_NONE},
        '{3'd2, 1'b1, 1'b1, EV_NONE}
    };

    gesture_plan_t gesture_plans [6] = '{
        '{1,   1,   1, 8, 120, 1'b0},
        '{0,   0,   0, 8, 60,  1'b1},
        '{255, 4,   1, 1, 245, 1'b0},
        '{2,   255, 1, 1, 245, 1'b1},
        '{6,   4,   0, 8, 100, 1'b0},
        '{3,   2,   1, 5, 60,  1'b0}
    };

    key_click_classifier_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("key_click_classifier_core regression: fail");
        $finish;
    end

    function automatic int idle_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic click_kind_t classify_tick(input logic [2:0] k, input logic pin);
        logic              pressed;
        phase_t            ph;
        logic [TICK_W-1:0] cnt;
        click_kind_t       ev;
        if (int'(k) >= KEYS)
            return EV_NONE;
        pressed = (pin == cfg_level);
        ph      = key_phase_q[k];
        cnt     = key_ticks_q[k];
        ev      = EV_NONE;
        case (ph)
            PH_DEBOUNCE:
                ph = pressed ? PH_PRESSED : PH_IDLE;
            PH_PRESSED:
                if (pressed && cnt >= cfg_long)
                begin
                    ph  = PH_LONG;
                    cnt = '0;
                end
                else if (pressed)
                    cnt = cnt + 1'b1;
                else
                begin
                    ph  = PH_WAIT;
                    cnt = '0;
                end
            PH_LONG:
            begin
                cnt = '0;
                if (!pressed)
                begin
                    ph = PH_IDLE;
                    ev = EV_LONG;
                end
            end
            PH_WAIT:
                if (!pressed && cnt >= cfg_wait)
                begin
                    ph  = PH_IDLE;
                    cnt = '0;
                    ev  = EV_SINGLE;
                end
                else if (!pressed)
                    cnt = cnt + 1'b1;
                else
                begin
                    ph  = PH_SECOND;
                    cnt = '0;
                end
            PH_SECOND:
                if (pressed && cnt >= cfg_long)
                begin
                    ph  = PH_LONG;
                    cnt = '0;
                    ev  = EV_SINGLE;
                end
                else if (pressed)
                    cnt = cnt + 1'b1;
                else
                begin
                    ph  = PH_IDLE;
                    cnt = '0;
                    ev  = EV_DOUBLE;
                end
            default:
                ph = pressed ? PH_DEBOUNCE : PH_IDLE;
        endcase
        key_phase_q[k] = ph;
        key_ticks_q[k] = cnt;
        return ev;
    endfunction

    task automatic send_tick(input logic [2:0] k, input logic pin, input bit typed,
                             input click_kind_t typed_ev);
        int          gap;
        click_beat_t want;
        gap = idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {4'b0000, pin, k};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        want.key = k;
        want.ev  = classify_tick(k, pin);
        if (typed)
            want.ev = typed_ev;
        pending_clicks.push_back(want);
    endtask

    task automatic drain_clicks();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_clicks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input int idx, input logic [APB_DW-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_AW'(idx * 4);
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        case (idx)
            int'(REG_LONG_PRESS):  cfg_long  = value[TICK_W-1:0];
            int'(REG_DOUBLE_WAIT): cfg_wait  = value[TICK_W-1:0];
            int'(REG_PRESS_LEVEL): cfg_level = value[0];
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_check(input int idx, input logic [APB_DW-1:0] want);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = APB_AW'(idx * 4);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            $error("prdata reg %0d: expected %h, got %h", idx, want, prdata);
            err_count++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic load_thresholds(input int long_ticks, input int wait_ticks,
                                   input int level);
        apb_write(int'(REG_LONG_PRESS), APB_DW'(long_ticks));
        apb_write(int'(REG_DOUBLE_WAIT), APB_DW'(wait_ticks));
        apb_write(int'(REG_PRESS_LEVEL), APB_DW'(level));
        apb_check(int'(REG_LONG_PRESS), APB_DW'(cfg_long));
        apb_check(int'(REG_DOUBLE_WAIT), APB_DW'(cfg_wait));
        apb_check(int'(REG_PRESS_LEVEL), APB_DW'(cfg_level));
    endtask

    function automatic int draw_run(input int thr);
        int r;
        case ($urandom_range(0, 3))
            0:       r = $urandom_range(1, 3);
            1:       r = thr + $urandom_range(0, 3) - 1;
            2:       r = thr + $urandom_range(2, 6);
            default: r = $urandom_range(1, 2 * thr + 2);
        endcase
        return (r < 1) ? 1 : r;
    endfunction

    task automatic play_gestures(input gesture_plan_t plan);
        int         base;
        int         thr;
        logic [2:0] k;
        logic       pin;
        base    = $urandom_range(0, KEYS - 1);
        no_idle = plan.no_idle;
        for (int n = 0; n < plan.ticks; n++)
        begin
            k = 3'((base + $urandom_range(0, plan.num_keys - 1)) % KEYS);
            if ($urandom_range(0, 9) == 0)
                pin = 1'($urandom_range(0, 1));
            else
            begin
                if (run_left[k] <= 0)
                begin
                    run_level[k] = ~run_level[k];
                    thr = (run_level[k] == cfg_level) ? int'(cfg_long) + 2 : int'(cfg_wait) + 1;
                    run_left[k] = draw_run(thr);
                end
                pin = run_level[k];
                run_left[k]--;
            end
            send_tick(k, pin, 1'b0, EV_NONE);
        end
    endtask

    always @(posedge clk)
    begin : check_clicks
        click_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_clicks.size() == 0)
            begin
                $error("unexpected beat: m_tdata %h", m_tdata);
                err_count++;
            end
            else
            begin
                want = pending_clicks.pop_front();
                if (m_tdata[1:0] !== want.ev)
                begin
                    $error("click_kind: expected %0d, got %0d", want.ev, m_tdata[1:0]);
                    err_count++;
                end
                if (m_tdata[4:2] !== want.key)
                begin
                    $error("event_key: expected %0d, got %0d", want.key, m_tdata[4:2]);
                    err_count++;
                end
            end
        end
    end

    initial
    begin : receiver
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = idle_gap();
            @(negedge clk);
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        err_count = 0;
        no_idle   = 1'b0;
        cfg_long  = LONG_PRESS_RST;
        cfg_wait  = DOUBLE_WAIT_RST;
        cfg_level = 1'b0;
        for (int i = 0; i < KEYS; i++)
        begin
            key_phase_q[i] = PH_IDLE;
            key_ticks_q[i] = '0;
            run_level[i]   = 1'b1;
            run_left[i]    = 0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        apb_check(int'(REG_LONG_PRESS), APB_DW'(LONG_PRESS_RST));
        apb_check(int'(REG_DOUBLE_WAIT), APB_DW'(DOUBLE_WAIT_RST));
        apb_check(int'(REG_PRESS_LEVEL), '0);
        // address past the last register must not land anywhere
        apb_write(3, 32'hffff_ffff);
        load_thresholds(1, 1, 0);

        foreach (directed_rows[i])
            send_tick(directed_rows[i].key, directed_rows[i].pin,
                      directed_rows[i].typed, directed_rows[i].ev);

        foreach (gesture_plans[p])
        begin
            drain_clicks();
            load_thresholds(gesture_plans[p].long_ticks, gesture_plans[p].wait_ticks,
                            gesture_plans[p].level);
            play_gestures(gesture_plans[p]);
        end

        drain_clicks();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("key_click_classifier_core regression: pass");
        else
            $display("key_click_classifier_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
